FILE: rtl/ps2hc_pkg.sv
// ----------------------------------------------------------------------------
// ps2hc_pkg
// Types and constants shared by the PS/2 host command port: item codes,
// bus phases, and the packed command and result beats.
// ----------------------------------------------------------------------------
package ps2hc_pkg;

	// Argument buffer geometry
	localparam int ARG_DEPTH = 16;
	localparam int ARG_AW    = $clog2(ARG_DEPTH);

	// Request-to-send hold timer
	localparam int              HOLD_W     = 10;
	localparam logic [HOLD_W-1:0] HOLD_MAX   = '1;
	localparam logic [HOLD_W-1:0] RTS_RESET  = HOLD_W'(100);

	// Frame bit positions (bit counter values)
	localparam logic [3:0] BC_START  = 4'd0;
	localparam logic [3:0] BC_LAST_D = 4'd8;
	localparam logic [3:0] BC_PARITY = 4'd9;
	localparam logic [3:0] BC_ACK    = 4'd10;

	typedef enum logic [1:0] {
		CMD_BEGIN = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_EDGE  = 2'd2,
		CMD_TICK  = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_HOLD  = 2'd1,
		PH_WRITE = 2'd2,
		PH_READ  = 2'd3
	} phase_t;

	typedef struct packed {
		cmd_code_t   cmd;
		logic [7:0]  command_byte;
		logic [3:0]  n_args;
		logic [3:0]  n_returns;
		logic [3:0]  arg_index;
		logic [7:0]  arg_byte;
		logic        data_in;
	} cmd_t;

	typedef struct packed {
		logic        clock_low;
		logic        data_low;
		logic        busy_res;
		logic        byte_valid;
		logic [3:0]  byte_index;
		logic [7:0]  byte_value;
		logic        frame_error;
		logic        done_res;
	} res_t;

endpackage

FILE: rtl/ps2hc_engine.sv
// ----------------------------------------------------------------------------
// ps2hc_engine
// Transaction state, argument buffer memory and the per-beat next-state logic.
// Computes one result per accepted command beat.
// ----------------------------------------------------------------------------
module ps2hc_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          acc,
	input  ps2hc_pkg::cmd_t               item,
	input  logic                          cfg_we,
	input  logic [ps2hc_pkg::HOLD_W-1:0]  cfg_wdata,
	output ps2hc_pkg::res_t               res
);
	import ps2hc_pkg::*;

	// Whether the data wire is pulled low, given the frame position
	function automatic logic data_drive(phase_t ph, logic [3:0] bc, logic [7:0] sb,
		logic par);
		logic [2:0] pos;
		logic       drv;
		pos = 3'(bc - 4'd1);
		drv = 1'b0;
		if (ph == PH_WRITE) begin
			if (bc == BC_START) begin
				drv = 1'b1;
			end else if (bc <= BC_LAST_D) begin
				drv = ~sb[pos];
			end else if (bc == BC_PARITY) begin
				drv = ~par;
			end
		end
		return drv;
	endfunction

	phase_t              phase_q, phase_n;
	logic [3:0]          bit_cnt_q, bit_cnt_n;
	logic [7:0]          shift_q, shift_n, shift_eff;
	logic                par_q, par_n;
	logic [4:0]          bytes_done_q, bytes_done_n, bytes_inc;
	logic [3:0]          send_total_q, send_total_n;
	logic [3:0]          recv_total_q, recv_total_n;
	logic [HOLD_W-1:0]   hold_q, hold_n, hold_inc;
	logic [HOLD_W-1:0]   rts_q;
	logic                pend_q;
	logic [7:0]          rd_q;

	logic [7:0]          arg_mem [ARG_DEPTH];
	logic                mem_we;
	logic [ARG_AW-1:0]   mem_waddr;
	logic [7:0]          mem_wdata;
	logic                rd_en;
	logic [ARG_AW-1:0]   rd_addr;

	logic                valid_r, ferr_r, done_r;
	logic [2:0]          rpos;

	// Forward the argument fetched on the previous beat
	assign shift_eff = pend_q ? rd_q : shift_q;
	assign bytes_inc = bytes_done_q + 5'd1;
	assign hold_inc  = (hold_q == HOLD_MAX) ? hold_q : hold_q + HOLD_W'(1);
	assign rpos      = 3'(bit_cnt_q - 4'd1);

	// Next state for one beat
	always_comb begin
		phase_n      = phase_q;
		bit_cnt_n    = bit_cnt_q;
		shift_n      = shift_eff;
		par_n        = par_q;
		bytes_done_n = bytes_done_q;
		send_total_n = send_total_q;
		recv_total_n = recv_total_q;
		hold_n       = hold_q;
		mem_we       = 1'b0;
		mem_waddr    = item.arg_index[ARG_AW-1:0];
		mem_wdata    = item.arg_byte;
		rd_en        = 1'b0;
		rd_addr      = bytes_done_q[ARG_AW-1:0];
		valid_r      = 1'b0;
		ferr_r       = 1'b0;
		done_r       = 1'b0;
		case (item.cmd)
			CMD_BEGIN: begin
				if (phase_q == PH_IDLE) begin
					send_total_n = item.n_args;
					recv_total_n = item.n_returns;
					bytes_done_n = 5'd0;
					phase_n      = PH_HOLD;
					shift_n      = item.command_byte;
					bit_cnt_n    = BC_START;
					par_n        = 1'b1;
					hold_n       = '0;
				end
			end
			CMD_LOAD: begin
				mem_we = 1'b1;
			end
			CMD_TICK: begin
				if (phase_q == PH_HOLD) begin
					hold_n = hold_inc;
					if (hold_inc >= rts_q) begin
						hold_n  = '0;
						phase_n = PH_WRITE;
					end
				end
			end
			CMD_EDGE: begin
				if (phase_q == PH_WRITE) begin
					if (bit_cnt_q < BC_LAST_D) begin
						par_n     = par_q ^ shift_eff[bit_cnt_q[2:0]];
						bit_cnt_n = bit_cnt_q + 4'd1;
					end else if (bit_cnt_q == BC_LAST_D || bit_cnt_q == BC_PARITY) begin
						bit_cnt_n = bit_cnt_q + 4'd1;
					end else if ({1'b0, bytes_inc} > {2'b00, send_total_q}) begin
						// last byte written: turn around and read
						bytes_done_n = 5'd0;
						phase_n      = PH_READ;
						shift_n      = 8'd0;
						bit_cnt_n    = BC_START;
						par_n        = 1'b1;
					end else begin
						// fetch the next argument; it lands next cycle
						bytes_done_n = bytes_inc;
						rd_en        = 1'b1;
						phase_n      = PH_HOLD;
						bit_cnt_n    = BC_START;
						par_n        = 1'b1;
						hold_n       = '0;
					end
				end else if (phase_q == PH_READ) begin
					if (bit_cnt_q == BC_START) begin
						if (item.data_in) begin
							ferr_r  = 1'b1;
							shift_n = 8'd0;
							par_n   = 1'b1;
						end else begin
							bit_cnt_n = 4'd1;
						end
					end else if (bit_cnt_q <= BC_LAST_D) begin
						par_n          = par_q ^ item.data_in;
						shift_n[rpos]  = shift_eff[rpos] | item.data_in;
						bit_cnt_n      = bit_cnt_q + 4'd1;
					end else if (bit_cnt_q == BC_PARITY) begin
						if (item.data_in != par_q) begin
							ferr_r    = 1'b1;
							shift_n   = 8'd0;
							bit_cnt_n = BC_START;
							par_n     = 1'b1;
						end else begin
							bit_cnt_n = BC_ACK;
						end
					end else if (bit_cnt_q == BC_ACK) begin
						valid_r   = 1'b1;
						mem_we    = (bytes_done_q != 5'd0);
						mem_waddr = ARG_AW'(bytes_done_q - 5'd1);
						mem_wdata = shift_eff;
						shift_n   = 8'd0;
						bit_cnt_n = BC_START;
						par_n     = 1'b1;
						if ({1'b0, bytes_inc} <= {2'b00, recv_total_q}) begin
							bytes_done_n = bytes_inc;
						end else begin
							bytes_done_n = 5'd0;
							phase_n      = PH_IDLE;
							done_r       = 1'b1;
						end
					end else begin
						// unused counter value: restart quietly
						shift_n   = 8'd0;
						bit_cnt_n = BC_START;
						par_n     = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Assemble the result beat
	always_comb begin
		res.clock_low   = (phase_n == PH_IDLE) || (phase_n == PH_HOLD);
		res.data_low    = data_drive(phase_n, bit_cnt_n, shift_n, par_n);
		res.busy_res    = (phase_n != PH_IDLE);
		res.byte_valid  = valid_r;
		res.byte_index  = valid_r ? bytes_done_q[3:0] : 4'd0;
		res.byte_value  = valid_r ? shift_eff : 8'd0;
		res.frame_error = ferr_r;
		res.done_res    = done_r;
	end

	// Control state: advance on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_cnt_q    <= 4'd0;
			shift_q      <= 8'd0;
			par_q        <= 1'b1;
			bytes_done_q <= 5'd0;
			send_total_q <= 4'd0;
			recv_total_q <= 4'd0;
			hold_q       <= '0;
			pend_q       <= 1'b0;
		end else if (acc) begin
			phase_q      <= phase_n;
			bit_cnt_q    <= bit_cnt_n;
			shift_q      <= shift_n;
			par_q        <= par_n;
			bytes_done_q <= bytes_done_n;
			send_total_q <= send_total_n;
			recv_total_q <= recv_total_n;
			hold_q       <= hold_n;
			pend_q       <= rd_en;
		end
	end

	// Hold-time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rts_q <= RTS_RESET;
		end else if (cfg_we) begin
			rts_q <= cfg_wdata;
		end
	end

	// Argument buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (acc && mem_we) begin
			arg_mem[mem_waddr] <= mem_wdata;
		end
		if (acc && rd_en) begin
			rd_q <= arg_mem[rd_addr];
		end
	end

endmodule

FILE: rtl/ps2_host_command_port_top.sv
// A result beat is registered into the output register, or the skid when stalled.
// Throughput: one command beat per cycle while the skid is empty; the argument
// fetch at the end of a written byte uses a registered read of the buffer memory.
// A two-deep output stage (result register plus skid) keeps intake running
// while a result waits. Reset clears all control state; the buffer is not cleared.
// ----------------------------------------------------------------------------
// ps2_host_command_port_top
// PS/2 host transaction engine with valid/ready command and result channels
// and a write-only hold-time register.
// ----------------------------------------------------------------------------
module ps2_host_command_port_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  ps2hc_pkg::cmd_t               cmd_data,
	output logic                          res_valid,
	input  logic                          res_ready,
	output ps2hc_pkg::res_t               res_data,
	input  logic                          cfg_we,
	input  logic [ps2hc_pkg::HOLD_W-1:0]  cfg_wdata
);
	import ps2hc_pkg::*;

	logic  acc;
	res_t  res_n;
	res_t  out_q, skid_q;
	logic  out_valid_q, skid_valid_q;

	assign cmd_ready = !skid_valid_q;
	assign acc       = cmd_valid && cmd_ready;
	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	ps2hc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.item      (cmd_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res       (res_n)
	);

	// Output register with skid: drain skid first, else load the new beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (res_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= acc;
			end
		end else if (acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload moves alongside the valid bits
	always_ff @(posedge clk) begin
		if (res_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (acc) begin
				out_q <= res_n;
			end
		end else if (acc) begin
			skid_q <= res_n;
		end
	end

endmodule

FILE: rtl/ps2hc_chk.sv
// ----------------------------------------------------------------------------
// ps2hc_chk
// Port-level checks on the result channel of the PS/2 host command port.
// ----------------------------------------------------------------------------
module ps2hc_chk (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  logic             res_ready,
	input  ps2hc_pkg::res_t  res_data
);
	import ps2hc_pkg::*;

	// Hold a stalled result beat
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result beat dropped or changed while stalled");

	// Empty byte fields and no done flag when no byte completed
	a_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.byte_valid |->
			res_data.byte_index == 4'd0 && res_data.byte_value == 8'd0 &&
			!res_data.done_res)
		else $error("byte fields set without a received byte");

	// End of transaction releases the bus to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.done_res |->
			!res_data.busy_res && res_data.clock_low && !res_data.data_low)
		else $error("done without returning to idle");

	// Frame error restarts reception, so the engine is still reading
	a_ferr_read: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.frame_error |->
			res_data.busy_res && !res_data.byte_valid && !res_data.clock_low)
		else $error("frame error outside a read");

endmodule

bind ps2_host_command_port_top ps2hc_chk u_chk (.*);
